// ===== sv/cmi_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package cmi_pkg;

    // Field and datapath widths
    localparam int IDX_W       = 16;
    localparam int NB_W        = IDX_W + 1;
    localparam int NP_W        = 9;
    localparam int COORD_W     = 8;
    localparam int MID_W       = 25;
    localparam int GLOBAL_W    = 40;
    localparam int CFG_INDEX_W = 3;

    // Configuration register indices
    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_DIM_LENGTH = 3'd0,
        REG_BLOCK_SIZE = 3'd1,
        REG_TILE_SIZE  = 3'd2,
        REG_PROC_COUNT = 3'd3,
        REG_PROC_COORD = 3'd4
    } cmi_reg_t;

    // Command codes
    localparam logic CMD_GLOBAL = 1'b0;
    localparam logic CMD_LOCAL  = 1'b1;

    typedef struct packed {
        logic             cmd;
        logic [IDX_W-1:0] elem_index;
    } cmi_item_t;

    typedef struct packed {
        logic [COORD_W-1:0] owner_coord;
        logic               owned_here;
        logic [IDX_W-1:0]   local_index;
        logic [IDX_W-1:0]   global_index;
        logic [IDX_W-1:0]   tile_number;
        logic [IDX_W-1:0]   next_split;
        logic [IDX_W-1:0]   piece_length;
        logic [IDX_W-1:0]   local_slab_length;
    } cmi_result_t;

    // Side data carried along the divider rows
    typedef struct packed {
        logic             cmd;
        logic [IDX_W-1:0] idx;
    } cmi_a_side_t;

    typedef struct packed {
        logic             cmd;
        logic [IDX_W-1:0] idx;
        logic [IDX_W-1:0] qb;
        logic [IDX_W-1:0] rb;
    } cmi_b_side_t;

    typedef struct packed {
        logic                cmd;
        logic [IDX_W-1:0]    idx;
        logic [IDX_W-1:0]    rb;
        logic [NP_W-1:0]     owner;
        logic [IDX_W-1:0]    local_idx;
        logic [GLOBAL_W-1:0] global_idx;
    } cmi_c_side_t;

    typedef struct packed {
        logic [NB_W-1:0]  nb;
        logic [IDX_W-1:0] r1;
        logic [IDX_W-1:0] blk;
    } cmi_s2_side_t;

    // Saturate a wide value at a limit and keep the low field bits.
    function automatic logic [IDX_W-1:0] sat16(input logic [GLOBAL_W-1:0] x,
                                               input logic [GLOBAL_W-1:0] lim);
        logic [GLOBAL_W-1:0] y;
        y = (x > lim) ? lim : x;
        return y[IDX_W-1:0];
    endfunction

endpackage

`default_nettype wire

// ===== sv/cmi_div_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none

module cmi_div_cell #(
    parameter int NW = 16,
    parameter int DW = 16,
    parameter int SW = 1
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          en,
    input  wire logic          flush,
    input  wire logic          valid_in,
    input  wire logic [DW-1:0] rem_in,
    input  wire logic [NW-1:0] work_in,
    input  wire logic [DW-1:0] div_in,
    input  wire logic [SW-1:0] side_in,
    output logic               valid_out,
    output logic [DW-1:0]      rem_out,
    output logic [NW-1:0]      work_out,
    output logic [DW-1:0]      div_out,
    output logic [SW-1:0]      side_out
);

    logic          valid_reg;
    logic [DW-1:0] rem_reg;
    logic [DW-1:0] rem_next;
    logic [NW-1:0] work_reg;
    logic [NW-1:0] work_next;
    logic [DW-1:0] div_reg;
    logic [SW-1:0] side_reg;
    logic [DW:0]   trial;
    logic [DW:0]   diff;
    logic          take;

    // One restoring step: shift in the next dividend bit and try the divisor.
    always_comb
    begin
        trial     = {rem_in, work_in[NW-1]};
        diff      = trial - {1'b0, div_in};
        take      = (trial >= {1'b0, div_in});
        rem_next  = take ? diff[DW-1:0] : trial[DW-1:0];
        work_next = {work_in[NW-2:0], take};
    end

    // Valid bit of this cell.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (flush)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= valid_in;
        end
    end

    // Payload of this cell.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg  <= rem_next;
            work_reg <= work_next;
            div_reg  <= div_in;
            side_reg <= side_in;
        end
    end

    assign valid_out = valid_reg;
    assign rem_out   = rem_reg;
    assign work_out  = work_reg;
    assign div_out   = div_reg;
    assign side_out  = side_reg;

endmodule

`default_nettype wire

// ===== sv/cmi_div_chain.sv =====
`timescale 1ns / 1ps
`default_nettype none

module cmi_div_chain #(
    parameter int NW = 16,
    parameter int DW = 16,
    parameter int SW = 1
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          en,
    input  wire logic          flush,
    input  wire logic          valid_in,
    input  wire logic [NW-1:0] dividend,
    input  wire logic [DW-1:0] divisor,
    input  wire logic [SW-1:0] side_in,
    output logic               valid_out,
    output logic [NW-1:0]      quotient,
    output logic [DW-1:0]      remainder,
    output logic [SW-1:0]      side_out
);

    logic          valid_w [0:NW];
    logic [DW-1:0] rem_w   [0:NW];
    logic [NW-1:0] work_w  [0:NW];
    logic [DW-1:0] div_w   [0:NW];
    logic [SW-1:0] side_w  [0:NW];

    // Head of the row: the remainder starts at zero.
    assign valid_w[0] = valid_in;
    assign rem_w[0]   = '0;
    assign work_w[0]  = dividend;
    assign div_w[0]   = divisor;
    assign side_w[0]  = side_in;

    // One cell per quotient bit, most significant first.
    for (genvar k = 0; k < NW; k++)
    begin : g_cell
        cmi_div_cell #(
            .NW(NW),
            .DW(DW),
            .SW(SW)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (en),
            .flush    (flush),
            .valid_in (valid_w[k]),
            .rem_in   (rem_w[k]),
            .work_in  (work_w[k]),
            .div_in   (div_w[k]),
            .side_in  (side_w[k]),
            .valid_out(valid_w[k+1]),
            .rem_out  (rem_w[k+1]),
            .work_out (work_w[k+1]),
            .div_out  (div_w[k+1]),
            .side_out (side_w[k+1])
        );
    end

    assign valid_out = valid_w[NW];
    assign quotient  = work_w[NW];
    assign remainder = rem_w[NW];
    assign side_out  = side_w[NW];

endmodule

`default_nettype wire

// ===== sv/block_cyclic_index_mapper.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Block-cyclic index mapper: each transfer on the item channel carries one index, either global
// (cmd 0) or slab-local (cmd 1), and produces exactly one result transfer with the owner, the
// index in the other frame, the tile number, the next split and the slab length. The block
// takes one item per cycle while no result is stalled and the slab length is ready; each item
// passes through three rows of one-bit divider cells (16 for the block division, 16 for the process
// division, 40 for the tile division), two multiply stages and the output register. A stalled
// result holds the whole pipeline. After reset and after every configuration write the slab
// length is recomputed by a separate row of 34 divider cells and two stages, and items are
// held off until it is ready.
module block_cyclic_index_mapper #(
    parameter int INDEX_WIDTH = 16,
    parameter int PROC_WIDTH  = 8
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                item_valid,
    output logic                                     item_stall,
    input  wire cmi_pkg::cmi_item_t                  item,
    output logic                                     result_valid,
    input  wire logic                                result_stall,
    output cmi_pkg::cmi_result_t                     result,
    input  wire logic                                cfg_we,
    input  wire logic [cmi_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  wire logic [cmi_pkg::IDX_W-1:0]           cfg_data
);

    import cmi_pkg::*;

    localparam logic [GLOBAL_W-1:0] INDEX_MAX  = (GLOBAL_W'(1) << INDEX_WIDTH) - GLOBAL_W'(1);
    localparam logic [16:0]         PROC_LIMIT = 17'd1 << PROC_WIDTH;
    localparam logic [16:0]         PROC_MASK  = PROC_LIMIT - 17'd1;

    // Configuration registers
    logic [IDX_W-1:0]   dim_length_reg;
    logic [IDX_W-1:0]   block_size_reg;
    logic [IDX_W-1:0]   tile_size_reg;
    logic [NP_W-1:0]    proc_count_reg;
    logic [COORD_W-1:0] proc_coord_reg;

    logic [IDX_W-1:0]   blk_eff;
    logic [IDX_W-1:0]   tile_eff;
    logic [NP_W-1:0]    np_raw;
    logic [NP_W-1:0]    np_eff;
    logic [NP_W-1:0]    pc9;

    // Item path
    logic               adv;
    logic               a_valid_in;
    cmi_a_side_t        a_side_in;
    logic               a_valid;
    logic [IDX_W-1:0]   a_quot;
    logic [IDX_W-1:0]   a_rem;
    cmi_a_side_t        a_side;
    cmi_b_side_t        b_side_in;
    logic               b_valid;
    logic [IDX_W-1:0]   b_quot;
    logic [NP_W-1:0]    b_rem;
    cmi_b_side_t        b_side;

    logic [IDX_W-1:0]   mul_a;
    logic [IDX_W-1:0]   mul_b;
    logic [IDX_W-1:0]   mul_add;
    logic [2*IDX_W-1:0] m1_sum;
    logic               m1_valid_reg;
    logic               m1_cmd_reg;
    logic [IDX_W-1:0]   m1_idx_reg;
    logic [IDX_W-1:0]   m1_rb_reg;
    logic [NP_W-1:0]    m1_owner_reg;
    logic [MID_W-1:0]   m1_val_reg;

    logic [MID_W+IDX_W-1:0] m2_prod;
    cmi_c_side_t        m2_side_next;
    logic               m2_valid_reg;
    cmi_c_side_t        m2_side_reg;

    logic               c_valid;
    logic [GLOBAL_W-1:0] c_quot;
    logic [IDX_W-1:0]   c_rem;
    cmi_c_side_t        c_side;

    logic [IDX_W-1:0]   d_blk;
    logic [IDX_W-1:0]   d_tile;
    logic [IDX_W-1:0]   step;
    logic [IDX_W:0]     next_raw;
    logic [IDX_W-1:0]   limit;
    logic [IDX_W-1:0]   next_val;
    logic [IDX_W-1:0]   piece;
    logic [16:0]        owner_full;
    cmi_result_t        result_next;
    logic               result_valid_reg;
    cmi_result_t        result_reg;

    // Slab length path
    logic [NB_W-1:0]    s1_num;
    logic               s1_valid;
    logic [NB_W-1:0]    s1_quot;
    logic [IDX_W-1:0]   s1_rem;
    logic [IDX_W-1:0]   s1_side;
    cmi_s2_side_t       s2_side_in;
    logic               s2_valid;
    logic [NB_W-1:0]    s2_quot;
    logic [NP_W-1:0]    s2_rem;
    cmi_s2_side_t       s2_side;

    logic [NB_W-1:0]    cnt_next;
    logic [NP_W-1:0]    last_owner;
    logic               zero_next;
    logic               adj_next;
    logic [IDX_W-1:0]   dec_next;
    logic               sf1_valid_reg;
    logic [NB_W-1:0]    sf1_cnt_reg;
    logic [IDX_W-1:0]   sf1_blk_reg;
    logic [IDX_W-1:0]   sf1_dec_reg;
    logic               sf1_zero_reg;
    logic               sf1_adj_reg;
    logic [NB_W+IDX_W-1:0] slab_prod;
    logic [NB_W+IDX_W-1:0] slab_full;
    logic [IDX_W-1:0]   slab_next;
    logic               setup_ready_reg;
    logic [IDX_W-1:0]   slab_reg;

    // Configuration write decoder
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dim_length_reg <= 16'd100;
            block_size_reg <= 16'd32;
            tile_size_reg  <= 16'd64;
            proc_count_reg <= 9'd1;
            proc_coord_reg <= 8'd0;
        end
        else if (cfg_we)
        begin
            unique case (cmi_reg_t'(cfg_index))
                REG_DIM_LENGTH: dim_length_reg <= cfg_data;
                REG_BLOCK_SIZE: block_size_reg <= cfg_data;
                REG_TILE_SIZE:  tile_size_reg  <= cfg_data;
                REG_PROC_COUNT: proc_count_reg <= cfg_data[NP_W-1:0];
                REG_PROC_COORD: proc_coord_reg <= cfg_data[COORD_W-1:0];
                default:        ;
            endcase
        end
    end

    // Effective sizes: zero reads as one, and the process count is capped.
    always_comb
    begin
        blk_eff  = (block_size_reg == '0) ? 16'd1 : block_size_reg;
        tile_eff = (tile_size_reg == '0) ? 16'd1 : tile_size_reg;
        np_raw   = (proc_count_reg == '0) ? 9'd1 : proc_count_reg;
        np_eff   = ({8'd0, np_raw} > PROC_LIMIT) ? PROC_LIMIT[NP_W-1:0] : np_raw;
        pc9      = {1'b0, proc_coord_reg};
    end

    // The pipeline moves whenever the output register is free or being emptied.
    assign adv        = !result_valid_reg || !result_stall;
    assign item_stall = !(adv && setup_ready_reg);
    assign a_valid_in = item_valid && setup_ready_reg;
    assign a_side_in  = '{cmd: item.cmd, idx: item.elem_index};

    // Index divided by the block size.
    cmi_div_chain #(
        .NW(IDX_W),
        .DW(IDX_W),
        .SW($bits(cmi_a_side_t))
    ) u_div_blk (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (adv),
        .flush    (1'b0),
        .valid_in (a_valid_in),
        .dividend (item.elem_index),
        .divisor  (blk_eff),
        .side_in  (a_side_in),
        .valid_out(a_valid),
        .quotient (a_quot),
        .remainder(a_rem),
        .side_out (a_side)
    );

    assign b_side_in = '{cmd: a_side.cmd, idx: a_side.idx, qb: a_quot, rb: a_rem};

    // Block number divided by the process count.
    cmi_div_chain #(
        .NW(IDX_W),
        .DW(NP_W),
        .SW($bits(cmi_b_side_t))
    ) u_div_np (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (adv),
        .flush    (1'b0),
        .valid_in (a_valid),
        .dividend (a_quot),
        .divisor  (np_eff),
        .side_in  (b_side_in),
        .valid_out(b_valid),
        .quotient (b_quot),
        .remainder(b_rem),
        .side_out (b_side)
    );

    // First multiply: local index for a global input, global block number otherwise.
    always_comb
    begin
        mul_a   = (b_side.cmd == CMD_LOCAL) ? b_side.qb : b_quot;
        mul_b   = (b_side.cmd == CMD_LOCAL) ? {7'd0, np_eff} : blk_eff;
        mul_add = (b_side.cmd == CMD_LOCAL) ? {8'd0, proc_coord_reg} : b_side.rb;
        m1_sum  = (mul_a * mul_b) + {16'd0, mul_add};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m1_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            m1_valid_reg <= b_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            m1_cmd_reg   <= b_side.cmd;
            m1_idx_reg   <= b_side.idx;
            m1_rb_reg    <= b_side.rb;
            m1_owner_reg <= b_rem;
            m1_val_reg   <= m1_sum[MID_W-1:0];
        end
    end

    // Second multiply: global index of a slab-local input.
    always_comb
    begin
        m2_prod                 = m1_val_reg * blk_eff;
        m2_side_next.cmd        = m1_cmd_reg;
        m2_side_next.idx        = m1_idx_reg;
        m2_side_next.rb         = m1_rb_reg;
        m2_side_next.owner      = m1_owner_reg;
        if (m1_cmd_reg == CMD_LOCAL)
        begin
            m2_side_next.local_idx  = m1_idx_reg;
            m2_side_next.global_idx = m2_prod[GLOBAL_W-1:0]
                                      + {{(GLOBAL_W-IDX_W){1'b0}}, m1_rb_reg};
        end
        else
        begin
            m2_side_next.local_idx  = m1_val_reg[IDX_W-1:0];
            m2_side_next.global_idx = {{(GLOBAL_W-IDX_W){1'b0}}, m1_idx_reg};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m2_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            m2_valid_reg <= m1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            m2_side_reg <= m2_side_next;
        end
    end

    // Global index divided by the tile size.
    cmi_div_chain #(
        .NW(GLOBAL_W),
        .DW(IDX_W),
        .SW($bits(cmi_c_side_t))
    ) u_div_tile (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (adv),
        .flush    (1'b0),
        .valid_in (m2_valid_reg),
        .dividend (m2_side_reg.global_idx),
        .divisor  (tile_eff),
        .side_in  (m2_side_reg),
        .valid_out(c_valid),
        .quotient (c_quot),
        .remainder(c_rem),
        .side_out (c_side)
    );

    // Next split: the nearer of the block and tile boundaries, clamped to the frame end.
    always_comb
    begin
        d_blk    = blk_eff - c_side.rb;
        d_tile   = tile_eff - c_rem;
        step     = (d_blk < d_tile) ? d_blk : d_tile;
        next_raw = {1'b0, c_side.idx} + {1'b0, step};
        limit    = (c_side.cmd == CMD_LOCAL) ? slab_reg : dim_length_reg;
        next_val = (next_raw > {1'b0, limit}) ? limit : next_raw[IDX_W-1:0];
        piece    = (next_val > c_side.idx) ? (next_val - c_side.idx) : '0;

        if (c_side.cmd == CMD_LOCAL)
        begin
            owner_full             = {9'd0, proc_coord_reg} & PROC_MASK;
            result_next.owned_here = 1'b1;
        end
        else
        begin
            owner_full             = {8'd0, c_side.owner} & PROC_MASK;
            result_next.owned_here = (c_side.owner == pc9);
        end
        result_next.owner_coord       = owner_full[COORD_W-1:0];
        result_next.local_index       = sat16(GLOBAL_W'(c_side.local_idx), INDEX_MAX);
        result_next.global_index      = sat16(c_side.global_idx, INDEX_MAX);
        result_next.tile_number       = sat16(c_quot, INDEX_MAX);
        result_next.next_split        = sat16(GLOBAL_W'(next_val), INDEX_MAX);
        result_next.piece_length      = sat16(GLOBAL_W'(piece), INDEX_MAX);
        result_next.local_slab_length = sat16(GLOBAL_W'(slab_reg), INDEX_MAX);
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            result_valid_reg <= c_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            result_reg <= result_next;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // Slab length: number of blocks, rounded up, then blocks per process.
    assign s1_num = {1'b0, dim_length_reg} + {1'b0, blk_eff} - 17'd1;

    cmi_div_chain #(
        .NW(NB_W),
        .DW(IDX_W),
        .SW(IDX_W)
    ) u_div_nb (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (1'b1),
        .flush    (cfg_we),
        .valid_in (1'b1),
        .dividend (s1_num),
        .divisor  (blk_eff),
        .side_in  (blk_eff),
        .valid_out(s1_valid),
        .quotient (s1_quot),
        .remainder(s1_rem),
        .side_out (s1_side)
    );

    assign s2_side_in = '{nb: s1_quot, r1: s1_rem, blk: s1_side};

    cmi_div_chain #(
        .NW(NB_W),
        .DW(NP_W),
        .SW($bits(cmi_s2_side_t))
    ) u_div_cnt (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (1'b1),
        .flush    (cfg_we),
        .valid_in (s1_valid),
        .dividend (s1_quot),
        .divisor  (np_eff),
        .side_in  (s2_side_in),
        .valid_out(s2_valid),
        .quotient (s2_quot),
        .remainder(s2_rem),
        .side_out (s2_side)
    );

    // Block count of this process, and whether it holds the short last block.
    always_comb
    begin
        cnt_next   = s2_quot + {16'd0, (pc9 < s2_rem)};
        last_owner = (s2_rem == '0) ? (np_eff - 9'd1) : (s2_rem - 9'd1);
        zero_next  = (s2_side.nb == '0) || (pc9 >= np_eff);
        adj_next   = (cnt_next != '0) && (s2_side.r1 != (s2_side.blk - 16'd1))
                     && (last_owner == pc9);
        dec_next   = s2_side.blk - s2_side.r1 - 16'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sf1_valid_reg   <= 1'b0;
            setup_ready_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            sf1_valid_reg   <= 1'b0;
            setup_ready_reg <= 1'b0;
        end
        else
        begin
            sf1_valid_reg   <= s2_valid;
            setup_ready_reg <= sf1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        sf1_cnt_reg  <= cnt_next;
        sf1_blk_reg  <= s2_side.blk;
        sf1_dec_reg  <= dec_next;
        sf1_zero_reg <= zero_next;
        sf1_adj_reg  <= adj_next;
    end

    // Whole blocks times the block size, less the missing part of a short last block.
    always_comb
    begin
        slab_prod = sf1_cnt_reg * sf1_blk_reg;
        slab_full = slab_prod - {17'd0, (sf1_adj_reg ? sf1_dec_reg : 16'd0)};
        slab_next = sf1_zero_reg ? '0 : slab_full[IDX_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        slab_reg <= slab_next;
    end

    // A configuration write restarts the slab length computation.
    a_cfg_restart: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_we |=> !setup_ready_reg)
        else $error("slab length still marked ready after a configuration write");

    // A stalled result freezes the pipeline behind it.
    a_freeze: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid_reg && result_stall) |=> ($stable(c_valid) && $stable(m2_valid_reg)))
        else $error("pipeline moved while the result was stalled");

    // No item is taken while a result is stalled.
    a_no_take: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid_reg && result_stall) |-> item_stall)
        else $error("item transfer taken while the result was stalled");

endmodule

`default_nettype wire

// ===== sim/tb_block_cyclic_index_mapper.sv =====
`timescale 1ns / 1ps

module tb_block_cyclic_index_mapper;
    import cmi_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES   = 120;

    logic        clk;
    logic        rst_n;
    logic        item_valid;
    logic        item_stall;
    cmi_item_t   item;
    logic        result_valid;
    logic        result_stall;
    cmi_result_t result;
    logic        cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [IDX_W-1:0]       cfg_data;

    block_cyclic_index_mapper dut (
        .clk(clk), .rst_n(rst_n),
        .item_valid(item_valid), .item_stall(item_stall), .item(item),
        .result_valid(result_valid), .result_stall(result_stall), .result(result),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // Shadow copy of the configuration registers.
    longint unsigned dim_len_q, blk_size_q, tile_size_q, proc_cnt_q, proc_crd_q;

    cmi_item_t   pending_items[$];
    cmi_result_t expected_maps[$];

    int   send_idle_pct;
    int   recv_stall_pct;
    int   hold_off;
    int   errors;
    int   quiet_cycles;
    logic in_taken;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Append an item to the queue of items still to be offered.
    function automatic void queue_item(cmi_item_t it);
        pending_items = {pending_items, it};
    endfunction

    // Append a prediction to the queue of results still to arrive.
    function automatic void queue_expect(cmi_result_t r);
        expected_maps = {expected_maps, r};
    endfunction

    function automatic longint unsigned sat_idx(longint unsigned x);
        return (x > 64'hFFFF) ? 64'hFFFF : x;
    endfunction

    function automatic longint unsigned slab_offset(longint unsigned g, longint unsigned b,
                                                    longint unsigned n);
        return ((g / b) / n) * b + g % b;
    endfunction

    function automatic longint unsigned next_boundary(longint unsigned g, longint unsigned b,
                                                      longint unsigned t);
        longint unsigned a, c;
        a = (g / b + 1) * b;
        c = (g / t + 1) * t;
        return (a < c) ? a : c;
    endfunction

    // Work out the mapping of one index under the current configuration.
    function automatic cmi_result_t map_index(cmi_item_t it);
        longint unsigned b, t, n, nb, cnt, slab, rem, idx, owner, here, loc, glob, nxt, sp;
        cmi_result_t r;
        b = (blk_size_q == 0) ? 1 : blk_size_q;
        t = (tile_size_q == 0) ? 1 : tile_size_q;
        n = (proc_cnt_q == 0) ? 1 : proc_cnt_q;
        if (n > 256) n = 256;
        idx = it.elem_index;
        nb = (dim_len_q + b - 1) / b;
        slab = 0;
        if (nb != 0 && proc_crd_q < n)
        begin
            cnt = nb / n + ((proc_crd_q < nb % n) ? 1 : 0);
            slab = cnt * b;
            rem = dim_len_q % b;
            if (cnt > 0 && rem != 0 && (nb - 1) % n == proc_crd_q)
                slab -= b - rem;
        end
        if (it.cmd == CMD_GLOBAL)
        begin
            glob = idx;
            owner = (idx / b) % n;
            here = (owner == proc_crd_q) ? 1 : 0;
            loc = slab_offset(idx, b, n);
            nxt = next_boundary(idx, b, t);
            if (nxt > dim_len_q) nxt = dim_len_q;
        end
        else
        begin
            loc = idx;
            owner = proc_crd_q;
            here = 1;
            glob = ((idx / b) * n + proc_crd_q) * b + idx % b;
            sp = next_boundary(glob, b, t);
            if ((sp / b) % n != proc_crd_q) sp += (n - 1) * b;
            nxt = slab_offset(sp, b, n);
            if (nxt > slab) nxt = slab;
        end
        r.owner_coord       = owner[7:0];
        r.owned_here        = here[0];
        r.local_index       = 16'(sat_idx(loc));
        r.global_index      = 16'(sat_idx(glob));
        r.tile_number       = 16'(sat_idx(glob / t));
        r.next_split        = 16'(sat_idx(nxt));
        r.piece_length      = 16'(sat_idx((nxt > idx) ? nxt - idx : 0));
        r.local_slab_length = 16'(sat_idx(slab));
        return r;
    endfunction

    // Driver: offers queued items, holding a stalled payload steady.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (item_valid && !in_taken)
                item_valid <= 1'b1;
            else if (pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct)
            begin
                item_valid <= 1'b1;
                item <= pending_items[0];
            end
            else
                item_valid <= 1'b0;
        end
    end

    // Receiver stall pattern, with an optional long hold-off.
    always @(negedge clk)
    begin
        if (hold_off > 0)
        begin
            hold_off <= hold_off - 1;
            result_stall <= 1'b1;
        end
        else
            result_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // Monitor: records each item transfer and checks each result transfer
    // against the oldest expectation.
    always @(posedge clk)
    begin
        in_taken <= rst_n && item_valid && !item_stall;
        if (rst_n)
        begin
            if ((item_valid && !item_stall) || (result_valid && !result_stall))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (result_valid && !result_stall)
            begin
                if (expected_maps.size() == 0)
                begin
                    $display("%0t: unexpected result %h", $time, result);
                    errors <= errors + 1;
                end
                else
                begin
                    if (result !== expected_maps[0])
                    begin
                        $display("%0t: mismatch expected %h actual %h", $time,
                                 expected_maps[0], result);
                        errors <= errors + 1;
                    end
                    void'(expected_maps.pop_front());
                end
            end
            if (item_valid && !item_stall)
            begin
                queue_expect(map_index(item));
                void'(pending_items.pop_front());
            end
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Some tests failed");
                $finish;
            end
        end
    end

    task automatic write_reg(cmi_reg_t r, longint unsigned v);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= r;
        cfg_data <= v[15:0];
        @(negedge clk);
        cfg_we <= 1'b0;
        case (r)
            REG_DIM_LENGTH: dim_len_q = v & 64'hFFFF;
            REG_BLOCK_SIZE: blk_size_q = v & 64'hFFFF;
            REG_TILE_SIZE:  tile_size_q = v & 64'hFFFF;
            REG_PROC_COUNT: proc_cnt_q = v & 64'h1FF;
            default:        proc_crd_q = v & 64'hFF;
        endcase
    endtask

    task automatic configure(longint unsigned d, longint unsigned b, longint unsigned t,
                             longint unsigned n, longint unsigned c);
        write_reg(REG_DIM_LENGTH, d);
        write_reg(REG_BLOCK_SIZE, b);
        write_reg(REG_TILE_SIZE, t);
        write_reg(REG_PROC_COUNT, n);
        write_reg(REG_PROC_COORD, c);
    endtask

    task automatic wait_idle();
        while (pending_items.size() > 0 || item_valid || expected_maps.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    function automatic cmi_item_t rand_item(longint unsigned span);
        cmi_item_t it;
        it.cmd = 1'($urandom_range(1));
        if ($urandom_range(9) == 0)
            it.elem_index = 16'($urandom);
        else
            it.elem_index = 16'($urandom_range(32'(span)));
        return it;
    endfunction

    initial
    begin
        longint unsigned d, n;
        errors = 0;
        quiet_cycles = 0;
        in_taken = 1'b0;
        hold_off = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        rst_n = 1'b0;
        item_valid = 1'b0;
        item = '0;
        result_stall = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        dim_len_q = 100; blk_size_q = 32; tile_size_q = 64; proc_cnt_q = 1; proc_crd_q = 0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed items under the reset configuration.
        for (int i = 0; i < IDX_W; i++)
        begin
            queue_item('{cmd: CMD_GLOBAL, elem_index: 16'd1 << i});
        end
        queue_item('{cmd: CMD_GLOBAL, elem_index: 16'hFFFF});
        queue_item('{cmd: CMD_LOCAL, elem_index: 16'd0});
        queue_item('{cmd: CMD_LOCAL, elem_index: 16'd99});
        queue_item('{cmd: CMD_LOCAL, elem_index: 16'd100});
        queue_item('{cmd: CMD_LOCAL, elem_index: 16'hFFFF});
        wait_idle();

        // Zero sizes and counts, oversized count, coordinate outside the grid.
        configure(0, 0, 0, 0, 0);
        queue_item('{cmd: CMD_GLOBAL, elem_index: 16'd5});
        queue_item('{cmd: CMD_LOCAL, elem_index: 16'd5});
        wait_idle();
        configure(65535, 65535, 65535, 511, 255);
        queue_item('{cmd: CMD_GLOBAL, elem_index: 16'hFFFF});
        queue_item('{cmd: CMD_LOCAL, elem_index: 16'hFFFF});
        wait_idle();
        configure(1000, 7, 10, 4, 9);
        queue_item('{cmd: CMD_GLOBAL, elem_index: 16'd500});
        queue_item('{cmd: CMD_LOCAL, elem_index: 16'd3});
        wait_idle();

        // Long receiver hold-off while the sender keeps offering.
        configure(1000, 5, 12, 3, 1);
        repeat (150) queue_item(rand_item(1100));
        hold_off = 400;
        wait_idle();

        // Random phases across idling patterns and settings.
        for (int ph = 0; ph < 16; ph++)
        begin
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 79; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 79; end
                default: begin send_idle_pct = 14; recv_stall_pct = 14; end
            endcase
            d = (ph == 5) ? 65535 : $urandom_range(1, 3000);
            n = (ph == 9) ? 256 : $urandom_range(1, 12);
            configure(d, $urandom_range(1, (ph == 7) ? 65535 : 64),
                      $urandom_range(1, (ph == 11) ? 65535 : 100),
                      n, (ph == 13) ? 255 : $urandom_range(0, n));
            repeat (45) queue_item(rand_item(d + 20));
            wait_idle();
        end

        if (errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// ===== block_cyclic_index_mapper.f =====
sv/cmi_pkg.sv
sv/cmi_div_cell.sv
sv/cmi_div_chain.sv
sv/block_cyclic_index_mapper.sv
sim/tb_block_cyclic_index_mapper.sv
